### design/mvp_pkg.sv
// Package for the masked value propagation block: request, response and
// memory cell types, and the neighbor offset table. No dependencies.
`default_nettype none
package mvp_pkg;

    localparam int NBR_CNT = 26;
    localparam logic [6:0] PASS_MAX = 7'd127;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;
    localparam logic RSP_REPORT = 1'b0;
    localparam logic RSP_READ = 1'b1;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [17:0] voxel_index;
        logic [31:0] voxel_value;
        logic        seed;
        logic        last_load;
    } t_req;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] filled_value;
        logic        reached;
        logic [6:0]  pass_count;
    } t_rsp;

    typedef struct packed {
        logic        reach;
        logic [31:0] value;
    } t_cell;

    // offsets in two's complement, 2 bits each
    typedef struct packed {
        logic [1:0] dx;
        logic [1:0] dy;
        logic [1:0] dz;
    } t_off;

    typedef struct packed {
        logic       busy;
        logic       toggle;
        logic       done;
        logic [6:0] passes;
    } t_fill_stat;

    localparam logic [1:0] M = 2'b11;
    localparam logic [1:0] Z = 2'b00;
    localparam logic [1:0] P = 2'b01;

    function automatic t_off nbr_off(input logic [4:0] n);
        t_off o;
        case (n)
            5'd0:  o = '{M, Z, Z};
            5'd1:  o = '{P, Z, Z};
            5'd2:  o = '{Z, M, Z};
            5'd3:  o = '{Z, P, Z};
            5'd4:  o = '{Z, Z, M};
            5'd5:  o = '{Z, Z, P};
            5'd6:  o = '{M, M, Z};
            5'd7:  o = '{M, P, Z};
            5'd8:  o = '{M, Z, M};
            5'd9:  o = '{M, Z, P};
            5'd10: o = '{P, M, Z};
            5'd11: o = '{P, P, Z};
            5'd12: o = '{P, Z, M};
            5'd13: o = '{P, Z, P};
            5'd14: o = '{Z, M, M};
            5'd15: o = '{Z, M, P};
            5'd16: o = '{Z, P, M};
            5'd17: o = '{Z, P, P};
            5'd18: o = '{M, M, M};
            5'd19: o = '{M, M, P};
            5'd20: o = '{M, P, M};
            5'd21: o = '{M, P, P};
            5'd22: o = '{P, M, M};
            5'd23: o = '{P, P, M};
            5'd24: o = '{P, M, P};
            5'd25: o = '{P, P, P};
            default: o = '{Z, Z, Z};
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

### design/mvp_bank.sv
// One voxel bank: synchronous memory of value and reached flag, one write
// port and one read port with registered read data. Uses mvp_pkg.
`default_nettype none
module mvp_bank
    import mvp_pkg::*;
#(
    parameter int DEPTH = 262144,
    parameter int AW = 18
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_cell         i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_cell              o_rdata
);

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### design/mvp_fill.sv
// Fill pass sequencer: walks the volume, reads each voxel and its neighbors
// from the source bank and writes the destination bank. Uses mvp_pkg.
`default_nettype none
module mvp_fill
    import mvp_pkg::*;
#(
    parameter int AW = 18,
    parameter int CW = 22
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire logic [6:0]    i_nx,
    input  wire logic [6:0]    i_ny,
    input  wire logic [6:0]    i_nz,
    input  wire logic [13:0]   i_sz,
    input  wire t_cell         i_rdata,
    output logic [AW-1:0]      o_raddr,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output t_cell              o_wdata,
    output t_fill_stat         o_stat
);

    typedef enum logic [2:0] {
        S_IDLE, S_SELF, S_CHK, S_SCAN, S_NCHK, S_NEXT
    } t_state;

    t_state          r_state;
    logic [6:0]      r_x, r_y, r_z;
    logic [CW-1:0]   r_here;
    logic [4:0]      r_n;
    logic [31:0]     r_self;
    logic            r_any;
    logic [6:0]      r_pass;

    t_off            off;
    logic signed [7:0] ax, ay, az;
    logic            inb;
    logic [CW-1:0]   ox, oy, oz, naddr;
    logic            last_vox;
    logic [6:0]      pass_n;

    always_comb begin
        off = nbr_off(r_n);
        ax = $signed({1'b0, r_x}) + $signed({{6{off.dx[1]}}, off.dx});
        ay = $signed({1'b0, r_y}) + $signed({{6{off.dy[1]}}, off.dy});
        az = $signed({1'b0, r_z}) + $signed({{6{off.dz[1]}}, off.dz});
        inb = (ax >= 0) && (ax < $signed({1'b0, i_nx}))
           && (ay >= 0) && (ay < $signed({1'b0, i_ny}))
           && (az >= 0) && (az < $signed({1'b0, i_nz}));
        ox = {{(CW-2){off.dx[1]}}, off.dx};
        oy = (off.dy == Z) ? '0 : (off.dy[1] ? -CW'(i_nx) : CW'(i_nx));
        oz = (off.dz == Z) ? '0 : (off.dz[1] ? -CW'(i_sz) : CW'(i_sz));
        naddr = r_here + ox + oy + oz;
        last_vox = (r_x == i_nx - 7'd1) && (r_y == i_ny - 7'd1) && (r_z == i_nz - 7'd1);
        pass_n = (r_pass == PASS_MAX) ? r_pass : r_pass + 7'd1;
    end

    always_comb begin
        o_raddr = (r_state == S_SCAN) ? naddr[AW-1:0] : r_here[AW-1:0];
        o_waddr = r_here[AW-1:0];
        o_we = 1'b0;
        o_wdata = i_rdata;
        case (r_state)
            S_CHK: begin
                o_we = i_rdata.reach;
            end
            S_SCAN: begin
                o_we = (r_n == 5'(NBR_CNT));
                o_wdata = '{reach: 1'b0, value: r_self};
            end
            S_NCHK: begin
                o_we = i_rdata.reach;
                o_wdata = '{reach: 1'b1, value: i_rdata.value};
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
        o_stat.busy = (r_state != S_IDLE);
        o_stat.toggle = (r_state == S_NEXT) && last_vox;
        o_stat.done = (r_state == S_NEXT) && last_vox && !r_any;
        o_stat.passes = pass_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
            r_here <= '0;
            r_n <= '0;
            r_any <= 1'b0;
            r_pass <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_x <= '0;
                        r_y <= '0;
                        r_z <= '0;
                        r_here <= '0;
                        r_any <= 1'b0;
                        r_pass <= '0;
                        r_state <= S_SELF;
                    end
                end
                S_SELF: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_self <= i_rdata.value;
                    r_n <= '0;
                    r_state <= i_rdata.reach ? S_NEXT : S_SCAN;
                end
                S_SCAN: begin
                    if (r_n == 5'(NBR_CNT)) begin
                        r_state <= S_NEXT;
                    end else if (inb) begin
                        r_state <= S_NCHK;
                    end else begin
                        r_n <= r_n + 5'd1;
                    end
                end
                S_NCHK: begin
                    if (i_rdata.reach) begin
                        r_any <= 1'b1;
                        r_state <= S_NEXT;
                    end else begin
                        r_n <= r_n + 5'd1;
                        r_state <= S_SCAN;
                    end
                end
                S_NEXT: begin
                    if (last_vox) begin
                        r_pass <= pass_n;
                        r_x <= '0;
                        r_y <= '0;
                        r_z <= '0;
                        r_here <= '0;
                        r_any <= 1'b0;
                        r_state <= r_any ? S_SELF : S_IDLE;
                    end else begin
                        r_here <= r_here + CW'(1);
                        r_state <= S_SELF;
                        if (r_x != i_nx - 7'd1) begin
                            r_x <= r_x + 7'd1;
                        end else begin
                            r_x <= '0;
                            if (r_y != i_ny - 7'd1) begin
                                r_y <= r_y + 7'd1;
                            end else begin
                                r_y <= '0;
                                r_z <= r_z + 7'd1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### design/masked_value_propagation_3d.sv
// Loads and reads: one request per cycle while busy is low, read data in the
// cycle after accept. Last load: fill passes from bank to bank, one memory
// read per neighbor checked, report strobed when the pass with no change ends.
// A configuration write or reset holds busy while volume sizes settle.
// Synchronous active-low reset. Requests are not accepted while busy.
`default_nettype none
module masked_value_propagation_3d
    import mvp_pkg::*;
#(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_req       i_req,
    output logic            o_strobe,
    output t_rsp            o_rsp,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data
);

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (AW > 22) ? AW : 22;

    function automatic logic [6:0] clamp(input logic [6:0] v, input int mx);
        logic [31:0] m;
        m = mx;
        if (v == 7'd0) return 7'd1;
        if (int'(v) > mx) return m[6:0];
        return v;
    endfunction

    logic [6:0]  r_size_x, r_size_y, r_size_z;
    logic [13:0] r_sz;
    logic [20:0] r_vol;
    logic [1:0]  r_settle;
    logic        r_cur;
    logic        r_strobe, r_kind, r_rd_in, r_rd_bank;
    logic [6:0]  r_pass_out;

    logic [6:0]  nx, ny, nz;
    logic        acc, in_vol, cfg_wr;
    logic [CW-1:0] idx;
    t_cell       rd_a, rd_b, rdata;
    t_cell       ld_cell;
    logic [AW-1:0] raddr, f_raddr, f_waddr;
    logic        f_we;
    t_cell       f_wdata;
    t_fill_stat  f_stat;
    logic        we_a, we_b;
    logic [AW-1:0] waddr;
    t_cell       wdata;

    assign nx = clamp(r_size_x, MAX_X);
    assign ny = clamp(r_size_y, MAX_Y);
    assign nz = clamp(r_size_z, MAX_Z);

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid && o_cfg_ready;
    assign busy = f_stat.busy || (r_settle != 2'd0);
    assign acc = start && !busy;
    assign idx = CW'(i_req.voxel_index);
    assign in_vol = (idx < CW'(r_vol)) && ({14'd0, i_req.voxel_index} < 32'(DEPTH));
    assign ld_cell = '{reach: i_req.seed, value: i_req.voxel_value};

    always_comb begin
        raddr = f_stat.busy ? f_raddr : idx[AW-1:0];
        waddr = f_stat.busy ? f_waddr : idx[AW-1:0];
        wdata = f_stat.busy ? f_wdata : ld_cell;
        we_a = 1'b0;
        we_b = 1'b0;
        if (f_stat.busy) begin
            we_a = f_we && r_cur;
            we_b = f_we && !r_cur;
        end else if (acc && i_req.kind == KIND_LOAD && in_vol) begin
            we_a = !r_cur;
            we_b = r_cur;
        end
        rdata = r_rd_bank ? rd_b : rd_a;
    end

    mvp_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_a)
    );

    mvp_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_b)
    );

    mvp_fill #(.AW(AW), .CW(CW)) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (acc && i_req.kind == KIND_LOAD && i_req.last_load),
        .i_nx    (nx),
        .i_ny    (ny),
        .i_nz    (nz),
        .i_sz    (r_sz),
        .i_rdata (rdata),
        .o_raddr (f_raddr),
        .o_we    (f_we),
        .o_waddr (f_waddr),
        .o_wdata (f_wdata),
        .o_stat  (f_stat)
    );

    always_ff @(posedge i_clk) begin
        r_sz <= {7'd0, nx} * {7'd0, ny};
        r_vol <= {7'd0, r_sz} * {14'd0, nz};
        r_rd_bank <= r_cur;
        r_kind <= (acc && i_req.kind == KIND_READ) ? RSP_READ : RSP_REPORT;
        r_rd_in <= in_vol;
        if (f_stat.done) begin
            r_pass_out <= f_stat.passes;
        end
        if (!i_rst_n) begin
            r_size_x <= 7'd64;
            r_size_y <= 7'd64;
            r_size_z <= 7'd64;
            r_settle <= 2'd2;
            r_cur <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (acc && i_req.kind == KIND_READ) || f_stat.done;
            if (f_stat.toggle) begin
                r_cur <= !r_cur;
            end
            if (cfg_wr) begin
                r_settle <= 2'd2;
                case (i_cfg_index)
                    CFG_SIZE_X: r_size_x <= i_cfg_data;
                    CFG_SIZE_Y: r_size_y <= i_cfg_data;
                    CFG_SIZE_Z: r_size_z <= i_cfg_data;
                    default: begin
                    end
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    always_comb begin
        o_strobe = r_strobe;
        o_rsp.result_kind = r_kind;
        o_rsp.filled_value = (r_kind == RSP_READ && r_rd_in) ? rdata.value : 32'd0;
        o_rsp.reached = (r_kind == RSP_READ && r_rd_in) ? rdata.reach : 1'b0;
        o_rsp.pass_count = (r_kind == RSP_READ) ? 7'd0 : r_pass_out;
    end

endmodule
`default_nettype wire

### bench/masked_value_propagation_3d_tb.sv
// Testbench for masked_value_propagation_3d: loads small voxel volumes, runs fills,
// reads voxels back and checks every response against an in-bench fill predictor.
// Depends on mvp_pkg and the masked_value_propagation_3d RTL.
`timescale 1ns / 100ps
`default_nettype none
module masked_value_propagation_3d_tb;
    import mvp_pkg::*;

    localparam int VOX_DEPTH = 262144;
    localparam int SETTLE_CYCLES = 60;
    localparam longint CYCLE_LIMIT = 6000000;
    localparam int RANDOM_ITEMS = 1850;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_req       i_req = '0;
    logic       o_strobe;
    t_rsp       o_rsp;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = CFG_SIZE_X;
    logic [6:0] i_cfg_data = '0;

    masked_value_propagation_3d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_strobe(o_strobe), .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    const int nb_dx[26] = '{-1, 1, 0, 0, 0, 0, -1, -1, -1, -1, 1, 1, 1, 1,
                            0, 0, 0, 0, -1, -1, -1, -1, 1, 1, 1, 1};
    const int nb_dy[26] = '{0, 0, -1, 1, 0, 0, -1, 1, 0, 0, -1, 1, 0, 0,
                            -1, -1, 1, 1, -1, -1, 1, 1, -1, 1, -1, 1};
    const int nb_dz[26] = '{0, 0, 0, 0, -1, 1, 0, 0, -1, 1, 0, 0, -1, 1,
                            -1, 1, -1, 1, -1, 1, -1, 1, -1, -1, 1, 1};

    t_cell      vox_mem [2][int];
    bit         cur_bank = 1'b0;
    logic [6:0] size_reg [3] = '{7'd64, 7'd64, 7'd64};
    t_rsp       rsp_q [$];
    int         errors = 0;
    int         items_sent = 0;
    int         gap_pct = 0;
    longint     cycles = 0;

    function automatic int dim(int axis);
        if (size_reg[axis] == 0) return 1;
        if (size_reg[axis] > 64) return 64;
        return size_reg[axis];
    endfunction

    function automatic int vol_count();
        return dim(0) * dim(1) * dim(2);
    endfunction

    function automatic logic [6:0] fill_volume();
        int nx, ny, nz, changes, ax, ay, az, here;
        logic [6:0] passes;
        t_cell src, dst;
        bit hit;
        nx = dim(0);
        ny = dim(1);
        nz = dim(2);
        passes = '0;
        do begin
            changes = 0;
            for (int z = 0; z < nz; z++)
                for (int y = 0; y < ny; y++)
                    for (int x = 0; x < nx; x++) begin
                        here = (z * ny + y) * nx + x;
                        src = vox_mem[cur_bank][here];
                        dst = src;
                        hit = 1'b0;
                        if (!src.reach) begin
                            for (int n = 0; n < 26 && !hit; n++) begin
                                ax = x + nb_dx[n];
                                ay = y + nb_dy[n];
                                az = z + nb_dz[n];
                                if (ax >= 0 && ax < nx && ay >= 0 && ay < ny &&
                                    az >= 0 && az < nz &&
                                    vox_mem[cur_bank][(az * ny + ay) * nx + ax].reach) begin
                                    dst.value = vox_mem[cur_bank][(az * ny + ay) * nx + ax].value;
                                    dst.reach = 1'b1;
                                    hit = 1'b1;
                                end
                            end
                            if (hit) changes++;
                        end
                        vox_mem[!cur_bank][here] = dst;
                    end
            cur_bank = !cur_bank;
            if (passes != PASS_MAX) passes++;
        end while (changes != 0);
        return passes;
    endfunction

    task automatic apply_request(t_req r);
        t_rsp rsp;
        t_cell c;
        bit in_vol;
        rsp = '0;
        in_vol = r.voxel_index < vol_count();
        if (r.kind == KIND_READ) begin
            rsp.result_kind = RSP_READ;
            if (in_vol) begin
                c = vox_mem[cur_bank][r.voxel_index];
                rsp.filled_value = c.value;
                rsp.reached = c.reach;
            end
            rsp_q.push_back(rsp);
        end else begin
            if (in_vol) vox_mem[cur_bank][r.voxel_index] = '{reach: r.seed, value: r.voxel_value};
            if (r.last_load) begin
                rsp.result_kind = RSP_REPORT;
                rsp.pass_count = fill_volume();
                rsp_q.push_back(rsp);
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR @%0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("masked_value_propagation_3d test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_strobe) begin
            if (rsp_q.size() == 0) begin
                report_mismatch("unexpected response kind", 32'(o_rsp.result_kind), 32'd0);
            end else begin
                want = rsp_q.pop_front();
                if (o_rsp.result_kind !== want.result_kind)
                    report_mismatch("result_kind", 32'(o_rsp.result_kind),
                                    32'(want.result_kind));
                if (o_rsp.filled_value !== want.filled_value)
                    report_mismatch("filled_value", o_rsp.filled_value, want.filled_value);
                if (o_rsp.reached !== want.reached)
                    report_mismatch("reached", 32'(o_rsp.reached), 32'(want.reached));
                if (o_rsp.pass_count !== want.pass_count)
                    report_mismatch("pass_count", 32'(o_rsp.pass_count),
                                    32'(want.pass_count));
            end
        end
    end

    task automatic send_request(bit kind, int idx, logic [31:0] val, bit sd, bit last);
        t_req r;
        r = '{kind: kind, voxel_index: idx[17:0], voxel_value: val, seed: sd, last_load: last};
        i_req <= r;
        start <= 1'b1;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        apply_request(r);
        items_sent++;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_responses();
        start <= 1'b0;
        while (rsp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(logic [1:0] index, logic [6:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        size_reg[index] = data;
    endtask

    task automatic set_sizes(logic [6:0] rx, logic [6:0] ry, logic [6:0] rz);
        drain_responses();
        write_size(CFG_SIZE_X, rx);
        write_size(CFG_SIZE_Y, ry);
        write_size(CFG_SIZE_Z, rz);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic int stored_index();
        int idx;
        for (int t = 0; t < 8; t++) begin
            idx = $urandom_range(vol_count() - 1);
            if (vox_mem[cur_bank].exists(idx)) return idx;
        end
        if (vol_count() < VOX_DEPTH) return $urandom_range(VOX_DEPTH - 1, vol_count());
        return -1;
    endfunction

    task automatic stray_request();
        int idx;
        if ($urandom_range(2) == 0 && vol_count() < VOX_DEPTH) begin
            idx = $urandom_range(VOX_DEPTH - 1, vol_count());
            send_request(KIND_LOAD, idx, $urandom, $urandom_range(1), 1'b0);
        end else begin
            idx = stored_index();
            if (idx >= 0) send_request(KIND_READ, idx, $urandom, $urandom_range(1), 1'b0);
        end
    endtask

    task automatic run_volume(logic [6:0] rx, logic [6:0] ry, logic [6:0] rz, int seed_pct);
        int order [$];
        int j, tmp, vol, tail_oob;
        set_sizes(rx, ry, rz);
        vol = vol_count();
        for (int i = 0; i < vol; i++) order.push_back(i);
        for (int i = vol - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        tail_oob = vol < VOX_DEPTH && $urandom_range(4) == 0;
        for (int i = 0; i < vol; i++) begin
            if ($urandom_range(9) == 0) stray_request();
            send_request(KIND_LOAD, order[i], rand_value(), $urandom_range(99) < seed_pct,
                         i == vol - 1 && !tail_oob);
        end
        if (tail_oob)
            send_request(KIND_LOAD, $urandom_range(VOX_DEPTH - 1, vol), $urandom, 1'b0, 1'b1);
        repeat ($urandom_range(vol / 2, vol + 2)) stray_request();
    endtask

    task automatic test_default_size();
        send_request(KIND_LOAD, 0, 32'h8000_0000, 1'b1, 1'b0);
        send_request(KIND_LOAD, VOX_DEPTH - 1, 32'h7fff_ffff, 1'b0, 1'b0);
        send_request(KIND_LOAD, 131072, 32'hffff_ffff, 1'b1, 1'b0);
        send_request(KIND_READ, 0, 32'h0, 1'b0, 1'b0);
        send_request(KIND_READ, VOX_DEPTH - 1, 32'hffff_ffff, 1'b1, 1'b1);
        send_request(KIND_READ, 131072, 32'h0, 1'b0, 1'b0);
    endtask

    task automatic test_small_fills();
        set_sizes(7'd2, 7'd1, 7'd1);
        send_request(KIND_LOAD, 0, 32'h1234_5678, 1'b1, 1'b0);
        send_request(KIND_LOAD, 1, 32'hdead_beef, 1'b0, 1'b1);
        send_request(KIND_READ, 0, 32'h0, 1'b0, 1'b0);
        send_request(KIND_READ, 1, 32'h0, 1'b0, 1'b0);
        send_request(KIND_READ, 5, 32'h0, 1'b0, 1'b0);
        send_request(KIND_LOAD, VOX_DEPTH - 1, 32'h5555_aaaa, 1'b1, 1'b1);
        send_request(KIND_READ, 1, 32'h0, 1'b0, 1'b0);
        set_sizes(7'd1, 7'd1, 7'd1);
        send_request(KIND_LOAD, 0, 32'hcafe_f00d, 1'b0, 1'b1);
        send_request(KIND_READ, 0, 32'h0, 1'b0, 1'b0);
    endtask

    task automatic test_random_volumes();
        logic [6:0] line_len;
        int axis;
        for (int phase = 0; phase < 4; phase++) begin
            gap_pct = (phase == 1) ? 52 : (phase == 3) ? 26 : 0;
            while (items_sent < RANDOM_ITEMS * (phase + 1) / 4) begin
                if ($urandom_range(19) == 0) begin
                    case ($urandom_range(2))
                        0: line_len = 7'd64;
                        1: line_len = 7'd127;
                        default: line_len = $urandom_range(65, 126);
                    endcase
                    axis = $urandom_range(2);
                    run_volume(axis == 0 ? line_len : 7'($urandom_range(1)),
                               axis == 1 ? line_len : 7'($urandom_range(1)),
                               axis == 2 ? line_len : 7'($urandom_range(1)),
                               $urandom_range(3));
                end else begin
                    run_volume($urandom_range(1, 4), $urandom_range(1, 4),
                               $urandom_range(1, 4), $urandom_range(60));
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_size();
        test_small_fills();
        test_random_volumes();
        drain_responses();
        if (errors == 0)
            $display("masked_value_propagation_3d test passed");
        else
            $display("masked_value_propagation_3d test failed");
        $finish;
    end

endmodule
`default_nettype wire
